@@ hw/rtl/neighbor_mean_pixel_filter_assert.svh @@
// Assertion macros for the neighbor mean pixel filter
`ifndef NEIGHBOR_MEAN_PIXEL_FILTER_ASSERT_SVH
`define NEIGHBOR_MEAN_PIXEL_FILTER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define NMPF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nmpf assertion failed");
// next-cycle implication
`define NMPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmpf assertion failed");
`else
`define NMPF_ASSERT_SAME(label, clk, rst, ante, cons)
`define NMPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/nmpf_pkg.sv @@
// Shared types and constants of the neighbor mean pixel filter
`default_nettype none
package nmpf_pkg;
  localparam logic [1:0] MODE_GRAY   = 2'd0;
  localparam logic [1:0] MODE_MEAN   = 2'd1;
  localparam logic [1:0] MODE_WEIGHT = 2'd2;
  localparam logic [1:0] MODE_PASS   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [15:0] GRAY_W0 = 16'd7471;
  localparam logic [15:0] GRAY_W1 = 16'd38470;
  localparam logic [15:0] GRAY_W2 = 16'd19595;
  // floor(x/5) == (x*13108)>>16 for x up to 1275
  localparam logic [24:0] MEAN_RECIP = 25'd13108;

  typedef struct packed {
    logic filt;      // a pixel of the row above is emitted
    logic interior;  // that pixel gets filtered
    logic last;      // input is in the last row, emits itself too
    logic done;      // last pixel of the frame
  } cls_t;
endpackage
`default_nettype wire

@@ hw/rtl/nmpf_if.sv @@
// Channel interfaces: pixel input, result output, configuration write
`default_nettype none
interface pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte0;
  logic [7:0] in_byte1;
  logic [7:0] in_byte2;
  modport source(output valid, in_byte0, in_byte1, in_byte2, input ready);
  modport sink(input valid, in_byte0, in_byte1, in_byte2, output ready);
endinterface

interface pix_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [11:0] pixel_row;
  logic [10:0] pixel_column;
  logic        frame_done;
  modport source(output valid, out_byte0, out_byte1, out_byte2, pixel_row,
                 pixel_column, frame_done, input ready);
  modport sink(input valid, out_byte0, out_byte1, out_byte2, pixel_row,
               pixel_column, frame_done, output ready);
endinterface

interface cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nmpf_pkg::CFG_IDX_W-1:0]  index;
  logic [nmpf_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/neighbor_mean_pixel_filter.sv @@
// Neighbor mean pixel filter: top level with configuration registers
// Output order: a pixel's filtered result appears one row later; a last-row pixel also
//   emits itself in S_EMIT2, after S_EMIT1 (and S_DIV when the pixel above takes the divide).
// Processing: one pixel at a time through S_IDLE, S_CALC and S_EMIT1, with S_DIV (8-step
//   restoring divide) for an interior pixel in weighted mode and S_EMIT2 on the last row;
//   first-row pixels skip S_EMIT1. A two-entry queue takes new pixels meanwhile.
// Reset (rst, synchronous): mode 1, 640 x 480, position and left pixel cleared.
// Row stores have no reset and no clearing pass.
`default_nettype none
`include "neighbor_mean_pixel_filter_assert.svh"
module neighbor_mean_pixel_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  pix_in_if.sink    pix_in,
  pix_out_if.source pix_out,
  cfg_if.sink       cfg
);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // config registers
  logic [1:0]  filter_mode;
  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  // front-to-back queue head
  logic           q_valid, q_pop;
  logic [23:0]    q_pix;
  logic [RW-1:0]  q_row;
  logic [CW-1:0]  q_col;
  nmpf_pkg::cls_t q_cls;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= nmpf_pkg::MODE_MEAN;
      frame_width  <= 12'd640;
      frame_height <= 13'd480;
    end else if (cfg.valid) begin
      case (cfg.index)
        nmpf_pkg::REG_MODE:   filter_mode  <= cfg.data[1:0];
        nmpf_pkg::REG_WIDTH:  frame_width  <= cfg.data[11:0];
        nmpf_pkg::REG_HEIGHT: frame_height <= cfg.data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // clamp size to 1..MAX
  always_comb begin
    if (frame_width == '0) eff_w = CW'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(frame_width);
    if (frame_height == '0) eff_h = RW'(1);
    else if (32'(frame_height) > 32'(MAX_HEIGHT)) eff_h = RW'(MAX_HEIGHT);
    else eff_h = RW'(frame_height);
  end

  nmpf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_pix   (q_pix),
    .q_row   (q_row),
    .q_col   (q_col),
    .q_cls   (q_cls)
  );

  nmpf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .mode    (filter_mode),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_pix   (q_pix),
    .q_row   (q_row),
    .q_col   (q_col),
    .q_cls   (q_cls),
    .pix_out (pix_out)
  );

  // frame end only on the last column
  `NMPF_ASSERT_SAME(a_done_col, clk, rst, pix_out.valid && pix_out.frame_done, pix_out.pixel_column == 11'(eff_w - CW'(1)))
  // mode and width register writes land
  `NMPF_ASSERT_NEXT(a_mode_wr, clk, rst, !rst && cfg.valid && cfg.ready && cfg.index == nmpf_pkg::REG_MODE, filter_mode == $past(cfg.data[1:0]))
  `NMPF_ASSERT_NEXT(a_width_wr, clk, rst, !rst && cfg.valid && cfg.ready && cfg.index == nmpf_pkg::REG_WIDTH, frame_width == $past(cfg.data[11:0]))
endmodule
`default_nettype wire

@@ hw/rtl/nmpf_front.sv @@
// Front end: accepts pixels, tracks position, classifies, queues work
`default_nettype none
module nmpf_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  pix_in_if.sink              pix_in,
  input  wire logic [CW-1:0]  eff_w,
  input  wire logic [RW-1:0]  eff_h,
  output logic                q_valid,
  input  wire logic           q_pop,
  output logic [23:0]         q_pix,
  output logic [RW-1:0]       q_row,
  output logic [CW-1:0]       q_col,
  output nmpf_pkg::cls_t      q_cls
);
  logic [CW-1:0] ccnt, ccnt_next;
  logic [RW-1:0] rcnt, rcnt_next;
  logic [CW-1:0] col, col_n;
  logic [RW-1:0] r1, row, row_n;
  logic          wrap_c;
  nmpf_pkg::cls_t cls;
  logic          accept;

  // two-entry queue
  logic [23:0]    qpix [2];
  logic [RW-1:0]  qrow [2];
  logic [CW-1:0]  qcol [2];
  nmpf_pkg::cls_t qcls [2];
  logic           wp, rp;
  logic [1:0]     cnt;

  assign pix_in.ready = (cnt != 2'd2);
  assign accept = pix_in.valid && pix_in.ready;

  always_comb begin
    // a smaller width set between frames restarts the column
    wrap_c = (ccnt >= eff_w);
    col    = wrap_c ? '0 : ccnt;
    r1     = wrap_c ? rcnt + RW'(1) : rcnt;
    row    = (r1 >= eff_h) ? '0 : r1;
    cls.filt     = (row != '0);
    cls.interior = (row >= RW'(2)) && (col != '0)
                   && (({1'b0, col} + (CW+1)'(2)) <= {1'b0, eff_w});
    cls.last     = (row == eff_h - RW'(1));
    cls.done     = cls.last && (col == eff_w - CW'(1));
    col_n = col + CW'(1);
    row_n = row + RW'(1);
    if (col_n >= eff_w) begin
      ccnt_next = '0;
      rcnt_next = (row_n >= eff_h) ? '0 : row_n;
    end else begin
      ccnt_next = col_n;
      rcnt_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
      rcnt <= '0;
      wp   <= 1'b0;
      rp   <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (accept) begin
        ccnt <= ccnt_next;
        rcnt <= rcnt_next;
        wp   <= ~wp;
      end
      if (q_pop && q_valid) rp <= ~rp;
      cnt <= cnt + 2'(accept) - 2'(q_pop && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qpix[wp] <= {pix_in.in_byte2, pix_in.in_byte1, pix_in.in_byte0};
      qrow[wp] <= row;
      qcol[wp] <= col;
      qcls[wp] <= cls;
    end
  end

  assign q_valid = (cnt != 2'd0);
  assign q_pix   = qpix[rp];
  assign q_row   = qrow[rp];
  assign q_col   = qcol[rp];
  assign q_cls   = qcls[rp];
endmodule
`default_nettype wire

@@ hw/rtl/nmpf_back.sv @@
// Back end: row stores, filter arithmetic, divider, result register
`default_nettype none
module nmpf_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 1),
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     mode,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire logic [23:0]    q_pix,
  input  wire logic [RW-1:0]  q_row,
  input  wire logic [CW-1:0]  q_col,
  input  wire nmpf_pkg::cls_t q_cls,
  pix_out_if.source           pix_out
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_DIV   = 5'b00100,
    S_EMIT1 = 5'b01000,
    S_EMIT2 = 5'b10000
  } state_t;

  state_t         state;
  logic [23:0]    it_pix;
  logic [RW-1:0]  it_row;
  logic [CW-1:0]  it_col;
  nmpf_pkg::cls_t it_cls;

  logic [23:0] prior_mem [MAX_WIDTH];
  logic [23:0] above_mem [MAX_WIDTH];
  logic [23:0] prior_c, prior_r, above_t;
  logic [23:0] left;
  logic [23:0] fpix, res_pix, mean_pix;
  logic        use_div;

  logic [9:0]  drem [3];
  logic [7:0]  dlow [3];
  logic [9:0]  dden [3];
  logic [2:0]  dcnt;
  logic [9:0]  num_hi [3];
  logic [7:0]  num_lo [3];
  logic [9:0]  den_a [3];
  logic [9:0]  step_rem [3];
  logic [7:0]  step_q [3];
  logic [23:0] gsum;
  logic [7:0]  gray;

  logic        ov, out_free, load1, load2;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !ov || pix_out.ready;
  assign load1    = (state == S_EMIT1) && out_free;
  assign load2    = (state == S_EMIT2) && out_free;
  assign res_pix  = use_div ? {dlow[2], dlow[1], dlow[0]} : fpix;

  assign gsum = 24'(nmpf_pkg::GRAY_W0) * 24'(prior_c[7:0])
              + 24'(nmpf_pkg::GRAY_W1) * 24'(prior_c[15:8])
              + 24'(nmpf_pkg::GRAY_W2) * 24'(prior_c[23:16]);
  assign gray = gsum[23:16];

  genvar gi;
  for (gi = 0; gi < 3; gi++) begin : g_byte
    logic [7:0]  cb, nl, nr, nt, nb;
    logic [7:0]  dl, dr, dt, db;
    logic [10:0] sum;
    logic [24:0] prod;
    logic [17:0] num;
    logic [10:0] t;
    logic        ge;

    assign cb = prior_c[8*gi +: 8];
    assign nl = left[8*gi +: 8];
    assign nr = prior_r[8*gi +: 8];
    assign nt = above_t[8*gi +: 8];
    assign nb = it_pix[8*gi +: 8];
    assign dl = (cb > nl) ? cb - nl : nl - cb;
    assign dr = (cb > nr) ? cb - nr : nr - cb;
    assign dt = (cb > nt) ? cb - nt : nt - cb;
    assign db = (cb > nb) ? cb - nb : nb - cb;

    assign sum  = 11'(cb) + 11'(nl) + 11'(nr) + 11'(nt) + 11'(nb);
    assign prod = 25'(sum) * nmpf_pkg::MEAN_RECIP;
    assign mean_pix[8*gi +: 8] = prod[23:16];

    assign num = 18'(cb) + 18'(nl) * 18'(dl) + 18'(nr) * 18'(dr)
               + 18'(nt) * 18'(dt) + 18'(nb) * 18'(db);
    assign num_hi[gi] = num[17:8];
    assign num_lo[gi] = num[7:0];
    assign den_a[gi]  = 10'd1 + 10'(dl) + 10'(dr) + 10'(dt) + 10'(db);

    // quotient fits 8 bits, so remainder starts at num>>8 (< den)
    assign t  = {drem[gi], dlow[gi][7]};
    assign ge = (t >= {1'b0, dden[gi]});
    assign step_rem[gi] = ge ? 10'(t - {1'b0, dden[gi]}) : t[9:0];
    assign step_q[gi]   = {dlow[gi][6:0], ge};
  end

  // row stores
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prior_c <= prior_mem[q_col[AW-1:0]];
      prior_r <= prior_mem[AW'(q_col + CW'(1))];
      above_t <= above_mem[q_col[AW-1:0]];
      prior_mem[q_col[AW-1:0]] <= q_pix;
    end
    if (load1) above_mem[it_col[AW-1:0]] <= res_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      left  <= '0;
      ov    <= 1'b0;
    end else begin
      if (load1 || load2) ov <= 1'b1;
      else if (pix_out.ready) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) state <= S_CALC;
        end
        S_CALC: begin
          if (!it_cls.filt) state <= it_cls.last ? S_EMIT2 : S_IDLE;
          else if (it_cls.interior && mode == nmpf_pkg::MODE_WEIGHT) state <= S_DIV;
          else state <= S_EMIT1;
        end
        S_DIV: begin
          if (dcnt == 3'd7) state <= S_EMIT1;
        end
        S_EMIT1: begin
          if (out_free) begin
            left  <= res_pix;
            state <= it_cls.last ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_pix <= q_pix;
      it_row <= q_row;
      it_col <= q_col;
      it_cls <= q_cls;
    end
    if (state == S_CALC) begin
      use_div <= 1'b0;
      dcnt    <= '0;
      if (!it_cls.interior) fpix <= prior_c;
      else begin
        case (mode)
          nmpf_pkg::MODE_GRAY:   fpix <= {gray, gray, gray};
          nmpf_pkg::MODE_MEAN:   fpix <= mean_pix;
          nmpf_pkg::MODE_WEIGHT: use_div <= 1'b1;
          default:               fpix <= prior_c;
        endcase
      end
      for (int i = 0; i < 3; i++) begin
        drem[i] <= num_hi[i];
        dlow[i] <= num_lo[i];
        dden[i] <= den_a[i];
      end
    end
    if (state == S_DIV) begin
      dcnt <= dcnt + 3'd1;
      for (int i = 0; i < 3; i++) begin
        drem[i] <= step_rem[i];
        dlow[i] <= step_q[i];
      end
    end
    if (load1) begin
      pix_out.out_byte0    <= res_pix[7:0];
      pix_out.out_byte1    <= res_pix[15:8];
      pix_out.out_byte2    <= res_pix[23:16];
      pix_out.pixel_row    <= 12'(it_row - RW'(1));
      pix_out.pixel_column <= 11'(it_col);
      pix_out.frame_done   <= 1'b0;
    end else if (load2) begin
      pix_out.out_byte0    <= it_pix[7:0];
      pix_out.out_byte1    <= it_pix[15:8];
      pix_out.out_byte2    <= it_pix[23:16];
      pix_out.pixel_row    <= 12'(it_row);
      pix_out.pixel_column <= 11'(it_col);
      pix_out.frame_done   <= it_cls.done;
    end
  end

  assign pix_out.valid = ov;
endmodule
`default_nettype wire
